FILE: rtl/bcr64_pkg.sv
package bcr64_pkg;

    // register indexes on the configuration port
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [15:0] LIMIT_RESET = 16'd16;

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;
    localparam logic [1:0] PH_3 = 2'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       bad_char;
        logic       last_out;
    } result_t;

    // results produced by one input item
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } item_res_t;

    // 6-bit value to alphabet character
    function automatic logic [7:0] sym_of(input logic [5:0] v);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd2) begin
            sym_of = 8'h2e + v8;
        end else if (v < 6'd28) begin
            sym_of = 8'h41 + v8 - 8'd2;
        end else if (v < 6'd54) begin
            sym_of = 8'h61 + v8 - 8'd28;
        end else begin
            sym_of = 8'h30 + v8 - 8'd54;
        end
    endfunction

    // character to {valid, value}; anything above 127 is invalid
    function automatic logic [6:0] val_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        val_of = 7'd0;
        if (c == 8'h2e) begin
            val_of = {1'b1, 6'd0};
        end else if (c == 8'h2f) begin
            val_of = {1'b1, 6'd1};
        end else if (c >= 8'h41 && c <= 8'h5a) begin
            d = c - 8'h41 + 8'd2;
            val_of = {1'b1, d[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            d = c - 8'h61 + 8'd28;
            val_of = {1'b1, d[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd54;
            val_of = {1'b1, d[5:0]};
        end
    endfunction

endpackage

FILE: rtl/bcr64_core.sv
module bcr64_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  mode,
    input  logic [15:0]           limit,
    input  logic [7:0]            in_byte,
    input  logic                  last_in,
    input  logic                  advance,
    output bcr64_pkg::item_res_t  res
);

    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  carry_reg, carry_next;
    logic [15:0] bytes_reg, bytes_next;
    logic        halted_reg, halted_next;

    logic [1:0]  ph;
    logic [6:0]  dv;
    logic [5:0]  v;
    bcr64_pkg::item_res_t r;

    always_comb begin
        phase_next  = phase_reg;
        carry_next  = carry_reg;
        bytes_next  = bytes_reg;
        halted_next = halted_reg;
        r           = '0;
        ph          = (phase_reg == bcr64_pkg::PH_3) ? bcr64_pkg::PH_0 : phase_reg;
        dv          = bcr64_pkg::val_of(in_byte);
        v           = dv[5:0];

        if (mode == bcr64_pkg::MODE_ENCODE) begin
            case (ph)
                bcr64_pkg::PH_0: begin
                    r.res0.out_byte = bcr64_pkg::sym_of(in_byte[7:2]);
                    r.count         = 2'd1;
                    carry_next      = {in_byte[1:0], 4'b0000};
                    phase_next      = bcr64_pkg::PH_1;
                end
                bcr64_pkg::PH_1: begin
                    r.res0.out_byte = bcr64_pkg::sym_of({carry_reg[5:4], in_byte[7:4]});
                    r.count         = 2'd1;
                    carry_next      = {in_byte[3:0], 2'b00};
                    phase_next      = bcr64_pkg::PH_2;
                end
                default: begin
                    r.res0.out_byte = bcr64_pkg::sym_of({carry_reg[5:2], in_byte[7:6]});
                    r.res1.out_byte = bcr64_pkg::sym_of(in_byte[5:0]);
                    r.count         = 2'd2;
                    carry_next      = 6'd0;
                    phase_next      = bcr64_pkg::PH_0;
                end
            endcase
            // partial group closes with one more character
            if (last_in && phase_next != bcr64_pkg::PH_0) begin
                r.res1.out_byte = bcr64_pkg::sym_of(carry_next);
                r.count         = 2'd2;
            end
        end else if (!halted_reg && bytes_reg < limit) begin
            if (!dv[6]) begin
                r.res0.bad_char = 1'b1;
                r.count         = 2'd1;
                halted_next     = 1'b1;
            end else begin
                case (phase_reg)
                    bcr64_pkg::PH_0: begin
                        carry_next = v;
                        phase_next = bcr64_pkg::PH_1;
                    end
                    bcr64_pkg::PH_1: begin
                        r.res0.out_byte = {carry_reg, v[5:4]};
                        r.count         = 2'd1;
                        carry_next      = {2'b00, v[3:0]};
                        phase_next      = bcr64_pkg::PH_2;
                        bytes_next      = bytes_reg + 16'd1;
                    end
                    bcr64_pkg::PH_2: begin
                        r.res0.out_byte = {carry_reg[3:0], v[5:2]};
                        r.count         = 2'd1;
                        carry_next      = {4'b0000, v[1:0]};
                        phase_next      = bcr64_pkg::PH_3;
                        bytes_next      = bytes_reg + 16'd1;
                    end
                    default: begin
                        r.res0.out_byte = {carry_reg[1:0], v};
                        r.count         = 2'd1;
                        carry_next      = 6'd0;
                        phase_next      = bcr64_pkg::PH_0;
                        bytes_next      = bytes_reg + 16'd1;
                    end
                endcase
            end
        end

        if (last_in) begin
            if (r.count == 2'd2) begin
                r.res1.last_out = 1'b1;
            end else if (r.count == 2'd1) begin
                r.res0.last_out = 1'b1;
            end
            phase_next  = bcr64_pkg::PH_0;
            carry_next  = 6'd0;
            bytes_next  = 16'd0;
            halted_next = 1'b0;
        end
    end

    assign res = r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= bcr64_pkg::PH_0;
            carry_reg  <= 6'd0;
            bytes_reg  <= 16'd0;
            halted_reg <= 1'b0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            carry_reg  <= carry_next;
            bytes_reg  <= bytes_next;
            halted_reg <= halted_next;
        end
    end

endmodule

FILE: rtl/bcr64_out.sv
module bcr64_out (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  bcr64_pkg::item_res_t  res,
    input  logic                  m_ready,
    output logic                  m_valid,
    output bcr64_pkg::result_t    head,
    output logic                  free
);

    bcr64_pkg::result_t r0_reg, r1_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic               pop;

    assign m_valid = (cnt_reg != 2'd0);
    assign head    = r0_reg;
    assign pop     = m_valid && m_ready;
    // room for a new pair once the last held result leaves this cycle
    assign free    = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = res.count;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            r0_reg <= res.res0;
            r1_reg <= res.res1;
        end else if (pop) begin
            r0_reg <= r1_reg;
        end
    end

endmodule

FILE: rtl/bcrypt_radix64_codec.sv
// Streaming radix-64 codec on the bcrypt alphabet "./A-Za-z0-9", no padding.
// Mode register 0 encodes bytes into characters, 1 decodes characters into
// bytes up to the limit register's byte count per stream; s_last_in ends
// a stream and clears the group state. An input transfer is registered,
// then combinational table logic turns it into zero, one or two results
// held in a two-entry output pair. Items giving at most one result move
// at one per cycle while the receiver is ready; after an item giving two
// results the next item waits for the pair to free, so an encode stream
// runs at four characters per three bytes, set by the single output
// transfer per cycle. A decode error gives one result with m_bad_char set
// and m_out_byte zero, then output stays off until the stream's last item.
// Configuration writes take effect at once and must come while idle.
module bcrypt_radix64_codec (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_last_in,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_bad_char,
    output logic        m_last_out
);

    logic        mode_reg;
    logic [15:0] limit_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    bcr64_pkg::item_res_t res;
    bcr64_pkg::result_t   head;
    logic                 out_free;
    logic                 advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= bcr64_pkg::MODE_ENCODE;
            limit_reg <= bcr64_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == bcr64_pkg::CFG_MODE) begin
                mode_reg <= cfg_wdata[0];
            end else begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // the registered item moves on when it makes no result or the pair is free
    assign advance = in_valid_reg && ((res.count == 2'd0) || out_free);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_last_in;
        end
    end

    bcr64_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mode    (mode_reg),
        .limit   (limit_reg),
        .in_byte (in_byte_reg),
        .last_in (in_last_reg),
        .advance (advance),
        .res     (res)
    );

    bcr64_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && (res.count != 2'd0)),
        .res     (res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .head    (head),
        .free    (out_free)
    );

    assign m_out_byte = head.out_byte;
    assign m_bad_char = head.bad_char;
    assign m_last_out = head.last_out;

endmodule

FILE: rtl/bcr64_checker.sv
module bcr64_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_bad_char,
    input logic       m_last_out
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_bad_char) && $stable(m_last_out))
        else $error("result changed while stalled");

    // reset empties both stages
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    // error result carries a zero byte
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_char |-> m_out_byte == 8'd0)
        else $error("error result with nonzero byte");

endmodule

bind bcrypt_radix64_codec bcr64_checker u_bcr64_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_bad_char (m_bad_char),
    .m_last_out (m_last_out)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // run length guard, in clock cycles
    localparam int CYCLE_LIMIT = 200000;
    // cycles past the last result before the block counts as idle
    localparam int SETTLE_CYCLES = 8;
    // length of the long receiver hold-off
    localparam int HOLD_CYCLES = 64;

    // Tracks the codec's group state and configuration, turns each input
    // transfer into the characters or bytes it must produce, and matches
    // result transfers against them in order.
    class radix64_mirror;
        string                alphabet;
        logic                 mode;
        logic [15:0]          limit;
        logic [1:0]           grp_phase;
        logic [5:0]           carry;
        logic [15:0]          bytes_out;
        logic                 halted;
        bcr64_pkg::result_t   awaited_out[$];
        int                   errors;
        int                   inputs_seen;
        int                   outputs_seen;

        function new();
            alphabet  = "./ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
            mode      = bcr64_pkg::MODE_ENCODE;
            limit     = bcr64_pkg::LIMIT_RESET;
            grp_phase = bcr64_pkg::PH_0;
            carry     = '0;
            bytes_out = '0;
            halted    = 1'b0;
            errors    = 0;
            inputs_seen  = 0;
            outputs_seen = 0;
        endfunction

        function logic [7:0] char_for(input logic [5:0] v);
            return alphabet[v];
        endfunction

        // -1 for anything outside the alphabet
        function int code_value(input logic [7:0] c);
            if (c > 8'd127) return -1;
            for (int i = 0; i < 64; i++) begin
                if (alphabet[i] == c) return i;
            end
            return -1;
        endfunction

        function void set_reg(input logic idx, input logic [15:0] val);
            if (idx == bcr64_pkg::CFG_MODE) mode = val[0];
            else limit = val;
        endfunction

        // returns 1 unless the decoder ignored the character
        function bit translate_item(input logic [7:0] b, input logic lst);
            bcr64_pkg::result_t outs[2];
            int          n;
            int          v;
            logic [5:0]  vv;
            logic [1:0]  ph;
            logic [11:0] wide;
            bit          acted;
            n = 0;
            acted = 1'b1;
            wide = '0;
            inputs_seen++;
            if (mode == bcr64_pkg::MODE_ENCODE) begin
                // a decode stream may have left phase 3 behind
                ph = (grp_phase == bcr64_pkg::PH_3) ? bcr64_pkg::PH_0 : grp_phase;
                case (ph)
                    bcr64_pkg::PH_0: begin
                        outs[n++] = '{out_byte: char_for(b[7:2]),
                                      bad_char: 1'b0, last_out: 1'b0};
                        carry = {b[1:0], 4'b0000};
                        grp_phase = bcr64_pkg::PH_1;
                    end
                    bcr64_pkg::PH_1: begin
                        outs[n++] = '{out_byte: char_for({carry[5:4], b[7:4]}),
                                      bad_char: 1'b0, last_out: 1'b0};
                        carry = {b[3:0], 2'b00};
                        grp_phase = bcr64_pkg::PH_2;
                    end
                    default: begin
                        outs[n++] = '{out_byte: char_for({carry[5:2], b[7:6]}),
                                      bad_char: 1'b0, last_out: 1'b0};
                        outs[n++] = '{out_byte: char_for(b[5:0]),
                                      bad_char: 1'b0, last_out: 1'b0};
                        carry = '0;
                        grp_phase = bcr64_pkg::PH_0;
                    end
                endcase
                // partial group closes with one extra character
                if (lst && grp_phase != bcr64_pkg::PH_0)
                    outs[n++] = '{out_byte: char_for(carry), bad_char: 1'b0, last_out: 1'b0};
            end else if (!halted && bytes_out < limit) begin
                v = code_value(b);
                vv = v[5:0];
                if (v < 0) begin
                    outs[n++] = '{out_byte: 8'h00, bad_char: 1'b1, last_out: 1'b0};
                    halted = 1'b1;
                end else begin
                    case (grp_phase)
                        bcr64_pkg::PH_0: begin
                            carry = vv;
                            grp_phase = bcr64_pkg::PH_1;
                        end
                        bcr64_pkg::PH_1: begin
                            wide = {4'b0000, carry, vv[5:4]};
                            carry = {2'b00, vv[3:0]};
                            grp_phase = bcr64_pkg::PH_2;
                        end
                        bcr64_pkg::PH_2: begin
                            wide = {2'b00, carry, vv[5:2]};
                            carry = {4'b0000, vv[1:0]};
                            grp_phase = bcr64_pkg::PH_3;
                        end
                        default: begin
                            wide = {carry, vv};
                            carry = '0;
                            grp_phase = bcr64_pkg::PH_0;
                        end
                    endcase
                    if (grp_phase != bcr64_pkg::PH_1) begin
                        outs[n++] = '{out_byte: wide[7:0], bad_char: 1'b0, last_out: 1'b0};
                        bytes_out++;
                    end
                end
            end else begin
                acted = 1'b0;
            end
            if (lst) begin
                if (n > 0) outs[n - 1].last_out = 1'b1;
                grp_phase = bcr64_pkg::PH_0;
                carry     = '0;
                bytes_out = '0;
                halted    = 1'b0;
            end
            for (int i = 0; i < n; i++) awaited_out.push_back(outs[i]);
            return acted;
        endfunction

        function void match_output(input logic [7:0] ob, input logic bc, input logic lo);
            bcr64_pkg::result_t want;
            outputs_seen++;
            if (awaited_out.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending: byte=%02h bad=%0b last=%0b",
                         $time, ob, bc, lo);
                return;
            end
            want = awaited_out.pop_front();
            if (want.out_byte !== ob || want.bad_char !== bc || want.last_out !== lo) begin
                errors++;
                $display("%0t: mismatch: expected %02h bad=%0b last=%0b, got %02h bad=%0b last=%0b",
                         $time, want.out_byte, want.bad_char, want.last_out, ob, bc, lo);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_last_in;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_bad_char;
    logic        m_last_out;

    radix64_mirror codec = new();

    // idle odds in percent per cycle, switched by the stimulus
    int tx_idle_pct = 6;
    int rx_idle_pct = 52;
    // a bump of hold_asks asks the receiver for one long hold-off
    int hold_asks = 0;
    int holds_done = 0;
    int cycle_count = 0;

    bcrypt_radix64_codec uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_last_in  (s_last_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_bad_char (m_bad_char),
        .m_last_out (m_last_out)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Run guard: a hang or a lost result ends up here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, codec.awaited_out.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result monitor: every accepted result transfer is checked at the edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            codec.match_output(m_out_byte, m_bad_char, m_last_out);
    end

    // Receiver: random ready at the current odds, plus the long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asks != holds_done) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_done++;
            end
            m_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // One input transfer. Entered and left at a falling edge; valid stays up
    // after the transfer so that back-to-back items keep it high throughout.
    task automatic send_item(input logic [7:0] b, input logic lst, output bit acted);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_in_byte = b;
        s_last_in = lst;
        do @(posedge aclk); while (!s_ready);
        acted = codec.translate_item(b, lst);
        @(negedge aclk);
    endtask

    task automatic send_chars(input string s, input bit last_at_end);
        bit acted;
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], last_at_end && (i == s.len() - 1), acted);
    endtask

    // Sender goes quiet until every expected result is back and the pipe
    // has had time to swallow items that produce nothing.
    task automatic wait_drained();
        s_valid = 1'b0;
        while (codec.awaited_out.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        codec.set_reg(idx, val);
    endtask

    // Random raw bytes in streams of 1..10; a phase may stop mid-stream so
    // that the next mode picks up a live group state.
    task automatic run_encode(input int n_items, input int pause_at);
        int left;
        bit acted;
        left = $urandom_range(10, 1);
        for (int i = 0; i < n_items; i++) begin
            if (i == pause_at) wait_drained();
            left--;
            send_item(8'($urandom_range(255)), left == 0, acted);
            if (left == 0) left = $urandom_range(10, 1);
        end
    endtask

    // Character streams: most are clean alphabet text; a fifth are dirty,
    // with bad ASCII and codes above 127 mixed in. Ignored characters
    // (past the limit or after an error) do not count toward n_items.
    task automatic run_decode(input int n_items, input int max_len);
        int         used;
        int         left;
        bit         dirty;
        bit         acted;
        logic [7:0] c;
        used  = 0;
        left  = $urandom_range(max_len, 1);
        dirty = ($urandom_range(99) < 20);
        while (used < n_items) begin
            if (!dirty || $urandom_range(99) >= 15) begin
                c = codec.char_for(6'($urandom_range(63)));
            end else if ($urandom_range(1)) begin
                c = 8'($urandom_range(127));
                while (codec.code_value(c) >= 0) c = 8'($urandom_range(127));
            end else begin
                c = 8'($urandom_range(255, 128));
            end
            left--;
            send_item(c, left == 0, acted);
            if (acted) used++;
            if (left == 0) begin
                left  = $urandom_range(max_len, 1);
                dirty = ($urandom_range(99) < 20);
            end
        end
    endtask

    initial begin
        bit taken;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = bcr64_pkg::CFG_MODE;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_in_byte = '0;
        s_last_in = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // --- directed: encode at reset settings ---
        // full group of extremes, then one- and two-byte tails, then a full
        // group that ends the stream (no closing character)
        send_item(8'hff, 1'b0, taken);
        send_item(8'h00, 1'b0, taken);
        send_item(8'ha5, 1'b0, taken);
        send_item(8'h00, 1'b1, taken);
        send_item(8'hff, 1'b0, taken);
        send_item(8'hff, 1'b1, taken);
        send_item(8'h12, 1'b0, taken);
        send_item(8'h34, 1'b0, taken);
        send_item(8'h56, 1'b1, taken);

        // --- directed: decode ---
        // limit of 3 is hit after four characters; the bad one after it and
        // the last item are ignored, so no last_out shows for this stream
        wait_drained();
        write_reg(bcr64_pkg::CFG_MODE, 16'(bcr64_pkg::MODE_DECODE));
        write_reg(bcr64_pkg::CFG_LIMIT, 16'd3);
        send_chars(".9Az!.", 1'b1);
        // bad character halts the stream; the rest is dropped up to last
        wait_drained();
        write_reg(bcr64_pkg::CFG_LIMIT, bcr64_pkg::LIMIT_RESET);
        send_chars("A!BC", 1'b1);
        // code above 127 on the last item: error carries last_out
        send_item("Z", 1'b0, taken);
        send_item(8'h80, 1'b1, taken);
        // trailing partial group: one byte, then a lone char giving nothing
        send_chars("ab", 1'b1);
        send_chars("0", 1'b1);
        // zero limit decodes nothing
        wait_drained();
        write_reg(bcr64_pkg::CFG_LIMIT, 16'd0);
        send_chars("AB", 1'b1);

        // --- random: sender idles rarely, receiver often ---
        wait_drained();
        write_reg(bcr64_pkg::CFG_MODE, 16'(bcr64_pkg::MODE_ENCODE));
        write_reg(bcr64_pkg::CFG_LIMIT, 16'hffff);
        hold_asks++;    // long receiver stall while the sender keeps offering
        run_encode(70, -1);
        wait_drained();
        write_reg(bcr64_pkg::CFG_MODE, 16'(bcr64_pkg::MODE_DECODE));
        run_decode(70, 24);

        // --- random: receiver idles rarely, sender often ---
        tx_idle_pct = 52;
        rx_idle_pct = 6;
        wait_drained();
        write_reg(bcr64_pkg::CFG_LIMIT, 16'd1);
        run_decode(40, 6);
        wait_drained();
        write_reg(bcr64_pkg::CFG_MODE, 16'(bcr64_pkg::MODE_ENCODE));
        run_encode(60, 30);     // sender pauses halfway for a full drain
        wait_drained();
        write_reg(bcr64_pkg::CFG_MODE, 16'(bcr64_pkg::MODE_DECODE));
        write_reg(bcr64_pkg::CFG_LIMIT, 16'($urandom_range(20, 2)));
        run_decode(60, 16);

        // --- random: no idling on either side ---
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_drained();
        write_reg(bcr64_pkg::CFG_LIMIT, 16'($urandom_range(65535, 1)));
        run_decode(50, 24);
        wait_drained();
        write_reg(bcr64_pkg::CFG_MODE, 16'(bcr64_pkg::MODE_ENCODE));
        run_encode(50, -1);
        wait_drained();

        $display("Ran %0d input and %0d result transfers through encode and decode phases,",
                 codec.inputs_seen, codec.outputs_seen);
        $display("covering byte limits 0..65535, bad characters, mode switches and stalls.");
        if (codec.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bcr64_pkg.sv
rtl/bcr64_core.sv
rtl/bcr64_out.sv
rtl/bcrypt_radix64_codec.sv
rtl/bcr64_checker.sv
sim/tb_top.sv
